// ===== rtl/core/spf_pkg.sv =====
// Shared types and constants for the sample packet framer.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package spf_pkg;

  localparam int DATA_W   = 16;
  localparam int SAMPLE_W = 12;
  localparam int DROP_W   = 32;
  localparam int SEQ_W    = 16;
  localparam int CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_WORD = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_WORD    = 8'd1;

  localparam logic [DATA_W-1:0] HEADER_RESET = 16'hAA55;
  localparam logic [DATA_W-1:0] END_RESET    = 16'h55AA;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_SEND   = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE       = 5'b00001,
    ST_BUILD      = 5'b00010,
    ST_SEND_RD    = 5'b00100,
    ST_SEND_OUT   = 5'b01000,
    ST_SEND_EMPTY = 5'b10000
  } state_t;

  typedef struct packed {
    logic sample_wr;
    logic drop_inc;
    logic build_start;
    logic build_wr;
    logic build_done;
    logic send_start;
    logic send_rd;
    logic load_word;
    logic load_empty;
  } cmd_t;

  typedef struct packed {
    logic group_done;
    logic word_last;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/core/spf_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module spf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 36
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/spf_ctrl.sv =====
// Controller state machine of the sample packet framer.
// Depends on spf_pkg; drives the datapath by cmd_t and reads status_t.
`default_nettype none

module spf_ctrl
  import spf_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  input  wire logic    in_req,
  output logic         in_ready,
  input  wire status_t st,
  output cmd_t         cmd
);

  state_t state, state_next;
  logic   ready_flag, ready_flag_next;

  always_comb begin
    cmd             = '0;
    state_next      = state;
    ready_flag_next = ready_flag;
    in_ready        = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          if (in_req == REQ_SAMPLE) begin
            cmd.sample_wr = 1'b1;
            if (st.group_done) begin
              if (ready_flag) begin
                cmd.drop_inc = 1'b1;
              end else begin
                cmd.build_start = 1'b1;
                state_next      = ST_BUILD;
              end
            end
          end else if (ready_flag) begin
            cmd.send_start = 1'b1;
            state_next     = ST_SEND_RD;
          end else begin
            state_next = ST_SEND_EMPTY;
          end
        end
      end
      ST_BUILD: begin
        cmd.build_wr = 1'b1;
        if (st.word_last) begin
          cmd.build_done  = 1'b1;
          ready_flag_next = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      ST_SEND_RD: begin
        cmd.send_rd = 1'b1;
        state_next  = ST_SEND_OUT;
      end
      ST_SEND_OUT: begin
        if (st.out_free) begin
          cmd.load_word = 1'b1;
          if (st.word_last) begin
            ready_flag_next = 1'b0;
            state_next      = ST_IDLE;
          end else begin
            state_next = ST_SEND_RD;
          end
        end
      end
      ST_SEND_EMPTY: begin
        if (st.out_free) begin
          cmd.load_empty = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      ready_flag <= 1'b0;
    end else begin
      state      <= state_next;
      ready_flag <= ready_flag_next;
    end
  end

  a_build_sets_ready: assert property (@(posedge clk) disable iff (rst)
    cmd.build_done |=> ready_flag)
    else $error("Packet build finished without marking a packet as waiting.");

  a_empty_only_when_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEND_EMPTY) |-> !ready_flag)
    else $error("Empty reply issued while a packet was waiting.");

  a_no_drop_while_free: assert property (@(posedge clk) disable iff (rst)
    cmd.drop_inc |-> ready_flag && !cmd.build_start)
    else $error("Group dropped although no packet was waiting.");

  a_send_clears_ready: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_word && st.word_last) |=> !ready_flag && (state == ST_IDLE))
    else $error("Final packet word sent but packet still marked waiting.");

endmodule

`default_nettype wire

// ===== rtl/core/spf_dp.sv =====
// Datapath of the sample packet framer: config registers, staging samples,
// packet RAM, checksum, counters and the output register.
// Depends on spf_pkg and spf_ram; commanded by spf_ctrl.
`default_nettype none

module spf_dp
  import spf_pkg::*;
#(
  parameter int SAMPLES_PER_PACKET = 14,
  parameter int PACKET_LENGTH      = 18
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_valid,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [DATA_W-1:0]     cfg_data,
  input  wire logic [SAMPLE_W-1:0]   in_sample,
  input  wire cmd_t                  cmd,
  output status_t                    st,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [DATA_W-1:0]          out_word,
  output logic                       out_word_valid,
  output logic                       out_last,
  output logic [DROP_W-1:0]          out_drop_count
);

  localparam int CNTW  = $clog2(SAMPLES_PER_PACKET + 1);
  localparam int SIW   = (SAMPLES_PER_PACKET > 1) ? $clog2(SAMPLES_PER_PACKET) : 1;
  localparam int WW    = $clog2(PACKET_LENGTH);
  localparam int XW    = (WW > CNTW) ? WW : CNTW;
  localparam int DEPTH = 2 * PACKET_LENGTH;
  localparam int AW    = $clog2(DEPTH);

  logic [DATA_W-1:0]   header_word, end_word;
  logic [DATA_W-1:0]   hdr_snap, end_snap;
  logic [SAMPLE_W-1:0] staging [SAMPLES_PER_PACKET];
  logic [CNTW-1:0]     cnt;
  logic [WW-1:0]       widx;
  logic                fill_slot, ready_slot;
  logic [SEQ_W-1:0]    seq;
  logic [DROP_W-1:0]   drop;
  logic [DATA_W-1:0]   sum;

  logic [XW-1:0]       pidx;
  logic                is_payload;
  logic [DATA_W-1:0]   payload;
  logic [DATA_W-1:0]   build_word;
  logic [AW-1:0]       wr_addr, rd_addr;
  logic [DATA_W-1:0]   rd_data;

  assign st.group_done = (cnt >= CNTW'(SAMPLES_PER_PACKET - 1));
  assign st.word_last  = (widx == WW'(PACKET_LENGTH - 1));
  assign st.out_free   = !out_valid || out_ready;

  assign pidx       = XW'(widx) - XW'(2);
  assign is_payload = (widx >= WW'(2)) && (widx <= WW'(PACKET_LENGTH - 3));

  always_comb begin
    payload = '0;
    if (is_payload && (pidx < XW'(SAMPLES_PER_PACKET))) begin
      payload = DATA_W'(staging[pidx[SIW-1:0]]);
    end
  end

  always_comb begin
    priority if (widx == WW'(0)) begin
      build_word = hdr_snap;
    end else if (widx == WW'(1)) begin
      build_word = seq;
    end else if (widx == WW'(PACKET_LENGTH - 2)) begin
      build_word = sum;
    end else if (widx == WW'(PACKET_LENGTH - 1)) begin
      build_word = end_snap;
    end else begin
      build_word = payload;
    end
  end

  assign wr_addr = fill_slot ? (AW'(PACKET_LENGTH) + AW'(widx)) : AW'(widx);
  assign rd_addr = ready_slot ? (AW'(PACKET_LENGTH) + AW'(widx)) : AW'(widx);

  spf_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (cmd.build_wr),
    .wr_addr (wr_addr),
    .wr_data (build_word),
    .rd_en   (cmd.send_rd),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      header_word <= HEADER_RESET;
      end_word    <= END_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_HEADER_WORD) begin
        header_word <= cfg_data;
      end else if (cfg_index == CFG_END_WORD) begin
        end_word <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sample_wr && (cnt < CNTW'(SAMPLES_PER_PACKET))) begin
      staging[cnt[SIW-1:0]] <= in_sample;
    end
    if (cmd.build_start) begin
      hdr_snap <= header_word;
      end_snap <= end_word;
      sum      <= header_word ^ seq;
    end else if (cmd.build_wr && is_payload) begin
      sum <= sum ^ payload;
    end
    if (cmd.load_word) begin
      out_word       <= rd_data;
      out_word_valid <= 1'b1;
      out_last       <= st.word_last;
      out_drop_count <= drop;
    end else if (cmd.load_empty) begin
      out_word       <= '0;
      out_word_valid <= 1'b0;
      out_last       <= 1'b1;
      out_drop_count <= drop;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      widx       <= '0;
      fill_slot  <= 1'b0;
      ready_slot <= 1'b0;
      seq        <= '0;
      drop       <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.sample_wr) begin
        cnt <= st.group_done ? '0 : cnt + CNTW'(1);
      end
      if (cmd.drop_inc) begin
        drop <= drop + DROP_W'(1);
      end
      if (cmd.build_start || cmd.send_start) begin
        widx <= '0;
      end else if (cmd.build_wr || cmd.load_word) begin
        widx <= st.word_last ? '0 : widx + WW'(1);
      end
      if (cmd.build_done) begin
        ready_slot <= fill_slot;
        fill_slot  <= !fill_slot;
        seq        <= seq + SEQ_W'(1);
      end
      if (cmd.load_word || cmd.load_empty) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_word_index_range: assert property (@(posedge clk) disable iff (rst)
    widx <= WW'(PACKET_LENGTH - 1))
    else $error("Packet word index ran past the packet length.");

  a_sample_count_range: assert property (@(posedge clk) disable iff (rst)
    cnt < CNTW'(SAMPLES_PER_PACKET))
    else $error("Sample counter ran past the group size.");

  a_load_only_when_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_word || cmd.load_empty) |-> st.out_free)
    else $error("Output register overwritten while a result was still pending.");

  a_build_flips_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.build_done |=> (ready_slot != fill_slot))
    else $error("Waiting packet and fill half point at the same buffer half.");

endmodule

`default_nettype wire

// ===== rtl/core/sample_packet_framer_core.sv =====
// Sample packet framer, top level: stream ports, config port and the
// controller and datapath instances. Depends on spf_pkg, spf_ctrl and spf_dp.
//
// Each request with tuser 0 carries one 12-bit sample and is taken while the
// controller is idle. When a sample completes a group and no packet is waiting,
// the block writes the packet into its packet RAM, one word per cycle through
// the single write port; if a packet is waiting, the group is dropped and the
// drop count rises. A request with tuser 1 sends the waiting packet as
// PACKET_LENGTH results, each word first read from the packet RAM, whose read is
// registered, and then loaded into the output register, or one result with
// tuser 0 and tlast 1 when nothing waits. The output register lets the block
// take new samples while the final result is still held back by m_tready.
// The stores need no clearing pass after reset.
`default_nettype none

module sample_packet_framer_core
  import spf_pkg::*;
#(
  parameter int SAMPLES_PER_PACKET = 14,
  parameter int PACKET_LENGTH      = 18
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [15:0]          s_tdata,   // [11:0] sample, [15:12] zero
  input  wire logic                 s_tuser,   // [0] req_type
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [47:0]               m_tdata,   // [15:0] word, [47:16] drop_count
  output logic                      m_tuser,   // [0] word_valid
  output logic                      m_tlast,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DATA_W-1:0]    cfg_data
);

  cmd_t                cmd;
  status_t             st;
  logic [DATA_W-1:0]   out_word;
  logic [DROP_W-1:0]   out_drop_count;

  assign cfg_ready = !rst;
  assign m_tdata   = {out_drop_count, out_word};

  spf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_req   (s_tuser),
    .in_ready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  spf_dp #(
    .SAMPLES_PER_PACKET (SAMPLES_PER_PACKET),
    .PACKET_LENGTH      (PACKET_LENGTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_sample      (s_tdata[SAMPLE_W-1:0]),
    .cmd            (cmd),
    .st             (st),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .out_word       (out_word),
    .out_word_valid (m_tuser),
    .out_last       (m_tlast),
    .out_drop_count (out_drop_count)
  );

endmodule

`default_nettype wire

// ===== verif/sample_packet_framer_core_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for sample_packet_framer_core: sends samples and send requests,
// predicts every packet word and compares the result stream field by field.
// Depends on spf_pkg and the RTL of the block only.
module sample_packet_framer_core_tb;
  import spf_pkg::*;

  localparam int SAMPLES       = 14;
  localparam int PKT_LEN       = 18;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 2 * PKT_LEN + 8;
  localparam int HOLD_CYCLES   = 300;

  typedef struct packed {
    logic [DATA_W-1:0] word;
    logic              word_valid;
    logic              last;
    logic [DROP_W-1:0] drop_count;
  } frame_word_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [15:0]          s_tdata   = '0;
  logic                 s_tuser   = REQ_SAMPLE;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [47:0]          m_tdata;
  logic                 m_tuser;
  logic                 m_tlast;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_HEADER_WORD;
  logic [DATA_W-1:0]    cfg_data  = '0;

  // Predicted block state.
  logic [DATA_W-1:0]   hdr_reg;
  logic [DATA_W-1:0]   end_reg;
  logic [SAMPLE_W-1:0] stage_buf [SAMPLES];
  logic [DATA_W-1:0]   pkt_buf [2][PKT_LEN];
  int unsigned         fill_cnt;
  logic                wr_half;
  logic                pend;
  logic                pend_half;
  logic [SEQ_W-1:0]    seq_num;
  logic [DROP_W-1:0]   drop_cnt;

  frame_word_t expected_words[$];

  int src_idle_pct  = 38;
  int sink_idle_pct = 55;
  int hold_left     = 0;
  int cycle_count   = 0;
  int err_count     = 0;
  int n_requests    = 0;
  int n_sends       = 0;
  int n_words       = 0;
  int n_packets     = 0;

  sample_packet_framer_core #(
    .SAMPLES_PER_PACKET(SAMPLES),
    .PACKET_LENGTH(PKT_LEN)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // The receiver stalls at random, or holds off completely while a long hold is pending.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk) begin
    frame_word_t want;
    frame_word_t got;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[15:0], m_tuser, m_tlast, m_tdata[47:16]};
      n_words++;
      if (expected_words.size() == 0) begin
        $error("unexpected result: word %h word_valid %b last %b drop_count %0d",
               got.word, got.word_valid, got.last, got.drop_count);
        err_count++;
      end else begin
        want = expected_words.pop_front();
        if (got.word !== want.word) begin
          $error("word: expected %h, got %h", want.word, got.word);
          err_count++;
        end
        if (got.word_valid !== want.word_valid) begin
          $error("word_valid: expected %b, got %b", want.word_valid, got.word_valid);
          err_count++;
        end
        if (got.last !== want.last) begin
          $error("last: expected %b, got %b", want.last, got.last);
          err_count++;
        end
        if (got.drop_count !== want.drop_count) begin
          $error("drop_count: expected %0d, got %0d", want.drop_count, got.drop_count);
          err_count++;
        end
      end
    end
  end

  task automatic clear_framer_state();
    hdr_reg   = HEADER_RESET;
    end_reg   = END_RESET;
    fill_cnt  = 0;
    wr_half   = 1'b0;
    pend      = 1'b0;
    pend_half = 1'b0;
    seq_num   = '0;
    drop_cnt  = '0;
  endtask

  task automatic predict_framing(input logic req, input logic [SAMPLE_W-1:0] smp);
    logic [DATA_W-1:0] csum;
    logic [DATA_W-1:0] slot;
    int i;
    if (req == REQ_SAMPLE) begin
      stage_buf[fill_cnt] = smp;
      if (fill_cnt + 1 >= SAMPLES) begin
        fill_cnt = 0;
        if (pend) begin
          drop_cnt = drop_cnt + 1;
        end else begin
          csum = hdr_reg ^ seq_num;
          pkt_buf[wr_half][0] = hdr_reg;
          pkt_buf[wr_half][1] = seq_num;
          for (i = 0; i < PKT_LEN - 4; i++) begin
            slot = (i < SAMPLES) ? {{(DATA_W-SAMPLE_W){1'b0}}, stage_buf[i]} : '0;
            pkt_buf[wr_half][2+i] = slot;
            csum = csum ^ slot;
          end
          pkt_buf[wr_half][PKT_LEN-2] = csum;
          pkt_buf[wr_half][PKT_LEN-1] = end_reg;
          pend_half = wr_half;
          pend      = 1'b1;
          wr_half   = ~wr_half;
          seq_num   = seq_num + 1;
          n_packets++;
        end
      end else begin
        fill_cnt = fill_cnt + 1;
      end
    end else if (!pend) begin
      expected_words.push_back({{DATA_W{1'b0}}, 1'b0, 1'b1, drop_cnt});
    end else begin
      for (i = 0; i < PKT_LEN; i++)
        expected_words.push_back({pkt_buf[pend_half][i], 1'b1, 1'(i == PKT_LEN - 1), drop_cnt});
      pend = 1'b0;
    end
  endtask

  task automatic push_request(input logic req, input logic [SAMPLE_W-1:0] smp);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= {{(16-SAMPLE_W){1'b0}}, smp};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_framing(req, smp);
    n_requests++;
    if (req == REQ_SEND) n_sends++;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_HEADER_WORD) hdr_reg = val;
    else if (idx == CFG_END_WORD) end_reg = val;
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return SAMPLE_W'($urandom_range((1 << SAMPLE_W) - 1));
    endcase
  endfunction

  task automatic test_directed();
    logic [SAMPLE_W-1:0] edge_vals [SAMPLES];
    int k;
    edge_vals = '{12'h000, 12'hFFF, 12'hAAA, 12'h555, 12'h001, 12'h800, 12'hF0F,
                  12'h0F0, 12'h123, 12'hFED, 12'h7FF, 12'h801, 12'hFFE, 12'h001};
    push_request(REQ_SEND, '0);
    for (k = 0; k < SAMPLES; k++) push_request(REQ_SAMPLE, edge_vals[k]);
    for (k = 0; k < SAMPLES; k++) push_request(REQ_SAMPLE, ~edge_vals[k]);
    push_request(REQ_SEND, 12'hFFF);
    push_request(REQ_SEND, '0);
  endtask

  task automatic test_config(input logic [DATA_W-1:0] hdr, input logic [DATA_W-1:0] tail);
    wait_drained();
    write_reg(CFG_HEADER_WORD, hdr);
    write_reg(CFG_END_WORD, tail);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_random(input int count, input int src_pct, input int sink_pct);
    int k;
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    for (k = 0; k < count; k++) begin
      if ($urandom_range(11) == 0) push_request(REQ_SEND, pick_sample());
      else push_request(REQ_SAMPLE, pick_sample());
    end
  endtask

  task automatic test_backpressure();
    int k;
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    hold_left <= HOLD_CYCLES;
    for (k = 0; k < SAMPLES; k++) push_request(REQ_SAMPLE, pick_sample());
    push_request(REQ_SEND, '0);
    for (k = 0; k < SAMPLES; k++) push_request(REQ_SAMPLE, pick_sample());
    push_request(REQ_SEND, '0);
    push_request(REQ_SEND, '0);
  endtask

  initial begin
    clear_framer_state();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_config(16'h0000, 16'hFFFF);
    test_random(140, 38, 55);
    test_config(16'hFFFF, 16'h0000);
    test_random(140, 55, 38);
    test_config(DATA_W'($urandom), DATA_W'($urandom));
    test_backpressure();
    test_random(140, 0, 0);
    wait_drained();
    if (expected_words.size() != 0) begin
      $error("%0d expected results never arrived", expected_words.size());
      err_count++;
    end
    $display("tb: %0d requests (%0d sends), %0d results checked", n_requests, n_sends, n_words);
    $display("tb: %0d packets built, %0d groups dropped, %0d cycles", n_packets, drop_cnt,
             cycle_count);
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
